// ----- rtl/vdp_pkg.sv -----
`timescale 1ns / 1ps
package vdp_pkg;

	localparam int MAX_DIM   = 4096;
	localparam int DIM_W     = 13;
	localparam int SIZE_W    = 17;
	localparam int RATIO_W   = 16;
	localparam int CEN_W     = 12;
	localparam int MAXD_W    = 24;
	localparam int MIND_W    = 25;
	localparam int DIFF_W    = 25;
	localparam int OFS_W     = 14;
	localparam int SQ_W      = 24;
	localparam int NUM_W     = 34;
	localparam int DIV_BITS  = 12;
	localparam int MAG_W     = DIV_BITS + 1;
	localparam int FAC_W     = 25;
	localparam int LATENCY   = 19;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_SIZE   = 2'd2;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_SQUARE,
		CS_SUM,
		CS_SCALE,
		CS_DIFF,
		CS_DIVIDE
	} cfg_state_t;

	// Frame constants derived from the registers, held steady between recomputes.
	typedef struct packed {
		logic                      bypass;
		logic                      wide_x;
		logic [RATIO_W-1:0]        ratio;
		logic [CEN_W-1:0]          cx;
		logic [CEN_W-1:0]          cy;
		logic [MAXD_W-1:0]         maxd;
		logic signed [MIND_W-1:0]  mind;
		logic [DIFF_W-1:0]         diff;
	} cfg_t;

	// Data that rides alongside the divider pipeline.
	typedef struct packed {
		logic        pass;
		logic        sat;
		logic [31:0] pix;
	} side_t;

	function automatic logic [7:0] shade(input logic [7:0] c, input logic [FAC_W-1:0] f);
		logic [FAC_W+7:0] p;
		begin
			p = c * f;
			shade = (p[FAC_W+7:16] > 17'd255) ? 8'hFF : p[23:16];
		end
	endfunction

endpackage

// ----- rtl/vignette_darken_pixel.sv -----
`timescale 1ns / 1ps
// Radial vignette filter for one packed pixel (red 7:0, green 15:8, blue 23:16,
// alpha 31:24). A pixel is taken at each rising edge with start high and busy
// low, one per clock, and its darkened result appears on pixel_out with done
// high for exactly one cycle; results come out in order and the receiver
// cannot hold them off. The pipeline has 19 register stages: offset, aspect
// scaling, squaring, distance, saturation check, twelve restoring divider
// stages (one quotient bit each), factor squaring and the color multiply.
// Writing any register, and leaving reset, starts a recompute of the frame
// constants (center, limits and a 16-step aspect ratio division); busy is
// high during it and no pixel is taken. Registers must only be written while
// no pixel is in flight.
module vignette_darken_pixel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] pixel_in,
	input  logic [11:0] column,
	input  logic [11:0] row,
	output logic        done,
	output logic [31:0] pixel_out,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data
);

	vdp_pkg::cfg_t cfg;
	logic          accept;

	logic                               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [31:0]                        pix_s1, pix_s2, pix_s3, pix_s4, pix_s5, pix_s6;
	logic signed [vdp_pkg::OFS_W-1:0]   dx_s1, dy_s1, dx_s2, dy_s2;
	logic [vdp_pkg::SQ_W-1:0]           sqx_s3, sqy_s3;
	logic [vdp_pkg::NUM_W-1:0]          num_s4, num_s5;
	logic                               pass_s4, pass_s5, sat_s5, pass_s6;
	logic [vdp_pkg::FAC_W-1:0]          f_s6;

	logic signed [vdp_pkg::OFS_W-1:0]   sel;
	logic signed [30:0]                 sprod;
	logic signed [27:0]                 px, py;
	logic [24:0]                        dist_sq;
	logic signed [26:0]                 num;
	logic [25:0]                        nmag;
	logic                               near;
	logic                               dv_valid;
	logic [vdp_pkg::DIV_BITS-1:0]       dv_quo;
	vdp_pkg::side_t                     dv_side, side_s5;
	logic [vdp_pkg::MAG_W-1:0]          mag;

	assign accept = start && !busy;

	vdp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.busy      (busy)
	);

	// Stage 2 scales the offset along the wider axis by the Q15 aspect ratio,
	// with a floor shift.
	assign sel   = cfg.wide_x ? dx_s1 : dy_s1;
	assign sprod = sel * $signed({1'b0, cfg.ratio});

	// Stage 3 squares both offsets.
	assign px = dx_s2 * dx_s2;
	assign py = dy_s2 * dy_s2;

	// Stage 4 forms the squared distance and the dividend magnitude times 256.
	assign dist_sq = {1'b0, sqx_s3} + {1'b0, sqy_s3};
	assign near    = $signed({1'b0, dist_sq}) <= cfg.mind;
	assign num     = $signed({3'd0, cfg.maxd}) - $signed({2'd0, dist_sq});
	assign nmag    = num[26] ? 26'(-num) : num[25:0];

	// Quotients of 4096 or more all clamp every nonzero color to full scale,
	// so the divider only resolves the low twelve bits.
	assign side_s5 = '{pass: pass_s5, sat: sat_s5, pix: pix_s5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= dv_valid;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= pixel_in;
		dx_s1  <= $signed({2'd0, cfg.cx}) - $signed({2'd0, column});
		dy_s1  <= $signed({2'd0, cfg.cy}) - $signed({2'd0, row});

		pix_s2 <= pix_s1;
		dx_s2  <= cfg.wide_x ? sprod[28:15] : dx_s1;
		dy_s2  <= cfg.wide_x ? dy_s1 : sprod[28:15];

		pix_s3 <= pix_s2;
		sqx_s3 <= px[vdp_pkg::SQ_W-1:0];
		sqy_s3 <= py[vdp_pkg::SQ_W-1:0];

		pix_s4  <= pix_s3;
		pass_s4 <= cfg.bypass || near;
		num_s4  <= {nmag, 8'd0};

		pix_s5  <= pix_s4;
		pass_s5 <= pass_s4;
		num_s5  <= num_s4;
		sat_s5  <= {3'd0, num_s4} >= {cfg.diff, 12'd0};
	end

	vdp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (v_s5),
		.num_in    (num_s5),
		.side_in   (side_s5),
		.diff      (cfg.diff),
		.valid_out (dv_valid),
		.quo_out   (dv_quo),
		.side_out  (dv_side)
	);

	assign mag = dv_side.sat ? vdp_pkg::MAG_W'(1 << vdp_pkg::DIV_BITS) : {1'b0, dv_quo};

	always_ff @(posedge clk) begin
		pix_s6  <= dv_side.pix;
		pass_s6 <= dv_side.pass;
		f_s6    <= {12'd0, mag} * {12'd0, mag};

		if (pass_s6) begin
			pixel_out <= pix_s6;
		end else begin
			pixel_out <= {pix_s6[31:24], vdp_pkg::shade(pix_s6[23:16], f_s6),
				vdp_pkg::shade(pix_s6[15:8], f_s6), vdp_pkg::shade(pix_s6[7:0], f_s6)};
		end
	end

	assign done = v_s7;

`ifndef SYNTH
	// Every result strobe matches exactly one transfer, a fixed latency earlier.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(accept, vdp_pkg::LATENCY))
		else $error("result strobe does not line up with an accepted pixel");

	// A register write always starts a recompute of the frame constants.
	a_recompute: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> busy)
		else $error("register write did not start a recompute");

	// The divider pipeline carries the same item count as its feeding stage.
	a_div_flow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 == $past(v_s5, vdp_pkg::DIV_BITS + 1))
		else $error("divider pipeline lost or created an item");
`endif

endmodule

// ----- rtl/vdp_cfg.sv -----
`timescale 1ns / 1ps
module vdp_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [vdp_pkg::SIZE_W-1:0] cfg_data,
	output vdp_pkg::cfg_t             cfg,
	output logic                      busy
);

	logic [vdp_pkg::DIM_W-1:0]  width_q, height_q, dim_w;
	logic [vdp_pkg::SIZE_W-1:0] size_q;
	vdp_pkg::cfg_state_t        state_q, state_d;
	logic [3:0]                 cnt_q;
	logic [vdp_pkg::MAXD_W-1:0] sqx_q, sqy_q, maxd_q;
	logic signed [vdp_pkg::MIND_W-1:0] mind_q;
	logic [vdp_pkg::DIFF_W-1:0] diff_q;
	logic [27:0]                rem_q, dsh_q;
	logic [vdp_pkg::RATIO_W-1:0] quo_q;
	logic [vdp_pkg::CEN_W-1:0]  cx, cy;
	logic                       wide_x;
	logic signed [17:0]         factor;
	logic signed [42:0]         prod, pmag;
	logic signed [42:0]         pshift;

	assign dim_w  = (cfg_data[vdp_pkg::DIM_W-1:0] > 13'(vdp_pkg::MAX_DIM))
		? 13'(vdp_pkg::MAX_DIM) : cfg_data[vdp_pkg::DIM_W-1:0];
	assign cx     = width_q[vdp_pkg::DIM_W-1:1];
	assign cy     = height_q[vdp_pkg::DIM_W-1:1];
	assign wide_x = width_q > height_q;

	// mind = maxd * (1 - size), truncated toward zero.
	assign factor = 18'sd65536 - $signed({1'b0, size_q});
	assign prod   = $signed({1'b0, maxd_q}) * factor;
	assign pmag   = prod[42] ? -prod : prod;
	assign pshift = prod[42] ? -(pmag >>> 16) : (pmag >>> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd640;
			height_q <= 13'd480;
			size_q   <= 17'd32768;
			state_q  <= vdp_pkg::CS_SQUARE;
			cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					vdp_pkg::REG_WIDTH:  width_q <= dim_w;
					vdp_pkg::REG_HEIGHT: height_q <= dim_w;
					vdp_pkg::REG_SIZE:   size_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == vdp_pkg::CS_DIFF) begin
				cnt_q <= '0;
			end else if (state_q == vdp_pkg::CS_DIVIDE) begin
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vdp_pkg::CS_IDLE:   state_d = vdp_pkg::CS_IDLE;
			vdp_pkg::CS_SQUARE: state_d = vdp_pkg::CS_SUM;
			vdp_pkg::CS_SUM:    state_d = vdp_pkg::CS_SCALE;
			vdp_pkg::CS_SCALE:  state_d = vdp_pkg::CS_DIFF;
			vdp_pkg::CS_DIFF:   state_d = vdp_pkg::CS_DIVIDE;
			vdp_pkg::CS_DIVIDE: state_d = (cnt_q == 4'd15) ? vdp_pkg::CS_IDLE
				: vdp_pkg::CS_DIVIDE;
			default:            state_d = vdp_pkg::CS_SQUARE;
		endcase
		if (cfg_we) begin
			state_d = vdp_pkg::CS_SQUARE;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			vdp_pkg::CS_SQUARE: begin
				sqx_q <= cx * cx;
				sqy_q <= cy * cy;
			end
			vdp_pkg::CS_SUM: begin
				maxd_q <= sqx_q + sqy_q;
			end
			vdp_pkg::CS_SCALE: begin
				mind_q <= pshift[vdp_pkg::MIND_W-1:0];
			end
			vdp_pkg::CS_DIFF: begin
				diff_q <= 25'($signed({1'b0, maxd_q}) - mind_q);
				rem_q  <= {(wide_x ? height_q : width_q), 15'd0};
				dsh_q  <= {(wide_x ? width_q : height_q), 15'd0};
				quo_q  <= '0;
			end
			vdp_pkg::CS_DIVIDE: begin
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
					quo_q <= {quo_q[vdp_pkg::RATIO_W-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[vdp_pkg::RATIO_W-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
			end
			default: ;
		endcase
	end

	assign busy        = state_q != vdp_pkg::CS_IDLE;
	assign cfg.bypass  = (width_q == '0) || (height_q == '0) || (diff_q == '0);
	assign cfg.wide_x  = wide_x;
	assign cfg.ratio   = quo_q;
	assign cfg.cx      = cx;
	assign cfg.cy      = cy;
	assign cfg.maxd    = maxd_q;
	assign cfg.mind    = mind_q;
	assign cfg.diff    = diff_q;

endmodule

// ----- rtl/vdp_div.sv -----
`timescale 1ns / 1ps
module vdp_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid_in,
	input  logic [vdp_pkg::NUM_W-1:0]  num_in,
	input  vdp_pkg::side_t             side_in,
	input  logic [vdp_pkg::DIFF_W-1:0] diff,
	output logic                       valid_out,
	output logic [vdp_pkg::DIV_BITS-1:0] quo_out,
	output vdp_pkg::side_t             side_out
);

	logic                           valid_s [0:vdp_pkg::DIV_BITS];
	logic [vdp_pkg::NUM_W-1:0]      rem_s   [0:vdp_pkg::DIV_BITS];
	logic [vdp_pkg::DIV_BITS-1:0]   quo_s   [0:vdp_pkg::DIV_BITS];
	vdp_pkg::side_t                 side_s  [0:vdp_pkg::DIV_BITS];

	assign valid_s[0] = valid_in;
	assign rem_s[0]   = num_in;
	assign quo_s[0]   = '0;
	assign side_s[0]  = side_in;

	// One quotient bit per stage, most significant first.
	for (genvar k = 0; k < vdp_pkg::DIV_BITS; k++) begin : g_stage
		logic [36:0] dsh;
		logic        ge;
		assign dsh = {12'd0, diff} << (vdp_pkg::DIV_BITS - 1 - k);
		assign ge  = {3'd0, rem_s[k]} >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? 34'({3'd0, rem_s[k]} - dsh) : rem_s[k];
			quo_s[k+1]  <= quo_s[k]
				| (vdp_pkg::DIV_BITS'(ge) << (vdp_pkg::DIV_BITS - 1 - k));
			side_s[k+1] <= side_s[k];
		end
	end

	assign valid_out = valid_s[vdp_pkg::DIV_BITS];
	assign quo_out   = quo_s[vdp_pkg::DIV_BITS];
	assign side_out  = side_s[vdp_pkg::DIV_BITS];

endmodule

// ----- tb/vignette_darken_pixel_tb.sv -----
`timescale 1ns / 1ps
module vignette_darken_pixel_tb;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] pixel_in;
	logic [11:0] column;
	logic [11:0] row;
	logic        done;
	logic [31:0] pixel_out;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [16:0] cfg_data;

	// Shadow copy of the frame registers, kept in step with every write.
	logic [12:0] frame_w;
	logic [12:0] frame_h;
	logic [16:0] extent_q16;

	logic [31:0] pending_pixels[$];
	int          mismatch_count;

	vignette_darken_pixel uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pixel_in(pixel_in), .column(column), .row(row),
		.done(done), .pixel_out(pixel_out),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The run ends here if results stop arriving. The slowest correct run ends well
	// inside this limit, so this limit leaves plenty of margin.
	initial begin
		#4_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Floor division by 2^15, matching an arithmetic shift on negative values.
	function automatic longint floor_q15(input longint v);
		if (v >= 0)
			return v >>> 15;
		return -(((-v) + 32767) >>> 15);
	endfunction

	function automatic logic [7:0] darken_channel(input logic [7:0] c, input longint f);
		longint unsigned p;
		p = (longint'(c) * f) >> 16;
		return (p > 255) ? 8'hFF : p[7:0];
	endfunction

	// Predicts the darkened pixel from the shadow registers.
	function automatic logic [31:0] vignette_pixel(input logic [31:0] pix,
			input logic [11:0] col, input logic [11:0] rw);
		longint w, h, ratio, cx, cy, dx, dy, maxd, prod, mind, diff, dist_sq, v, mag, f;
		w = frame_w;
		h = frame_h;
		if (w == 0 || h == 0)
			return pix;
		ratio = (w > h) ? (h * 32768) / w : (w * 32768) / h;
		cx = w >>> 1;
		cy = h >>> 1;
		maxd = cx * cx + cy * cy;
		prod = maxd * (65536 - longint'(extent_q16));
		mind = (prod >= 0) ? (prod >>> 16) : -((-prod) >>> 16);
		diff = maxd - mind;
		if (diff == 0)
			return pix;
		dx = cx - longint'(col);
		dy = cy - longint'(rw);
		if (w > h)
			dx = floor_q15(dx * ratio);
		else
			dy = floor_q15(dy * ratio);
		dist_sq = dx * dx + dy * dy;
		if (dist_sq <= mind)
			return pix;
		v = ((maxd - dist_sq) * 256) / diff;
		mag = (v < 0) ? -v : v;
		if (mag > (1 << 24))
			mag = 1 << 24;
		f = mag * mag;
		return {pix[31:24], darken_channel(pix[23:16], f),
			darken_channel(pix[15:8], f), darken_channel(pix[7:0], f)};
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch: %s got %h expected %h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// Result monitor: done marks a one-cycle result that cannot be held off.
	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n && done) begin
			if (pending_pixels.size() == 0)
				report_mismatch("unexpected pixel_out", pixel_out, '0);
			else begin
				want = pending_pixels.pop_front();
				if (pixel_out !== want)
					report_mismatch("pixel_out", pixel_out, want);
			end
		end
	end

	// Random gap: mostly none or short, occasionally long.
	task automatic idle_gap();
		int n;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: n = 0;
			4, 5, 6, 7, 8: n = $urandom_range(1, 3);
			default: n = $urandom_range(10, 40);
		endcase
		repeat (n) @(posedge clk);
	endtask

	// Drives one transfer and records its prediction once it is accepted.
	task automatic send_pixel(input logic [31:0] pix, input logic [11:0] col,
			input logic [11:0] rw, input bit gaps);
		start <= 1'b1;
		pixel_in <= pix;
		column <= col;
		row <= rw;
		do
			@(posedge clk);
		while (busy);
		pending_pixels.push_back(vignette_pixel(pix, col, rw));
		if (gaps && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			@(posedge clk);
			idle_gap();
		end
	endtask

	// Waits until all predicted results have arrived, then lets the pipe drain.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (vdp_pkg::LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [16:0] value);
		logic [12:0] d;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		d = value[12:0];
		if (d > 13'(vdp_pkg::MAX_DIM))
			d = 13'(vdp_pkg::MAX_DIM);
		case (idx)
			vdp_pkg::REG_WIDTH: frame_w = d;
			vdp_pkg::REG_HEIGHT: frame_h = d;
			vdp_pkg::REG_SIZE: extent_q16 = value;
			default: ;
		endcase
	endtask

	task automatic set_frame(input logic [16:0] w, input logic [16:0] h,
			input logic [16:0] s);
		drain();
		write_register(vdp_pkg::REG_WIDTH, w);
		write_register(vdp_pkg::REG_HEIGHT, h);
		write_register(vdp_pkg::REG_SIZE, s);
	endtask

	// Extremes of every field, the center, corners and positions outside the frame.
	task automatic test_directed();
		send_pixel(32'h0000_0000, 12'd320, 12'd240, 0);
		send_pixel(32'hFFFF_FFFF, 12'd320, 12'd240, 0);
		send_pixel(32'hFFFF_FFFF, 12'd0, 12'd0, 0);
		send_pixel(32'h80FF_7F01, 12'd639, 12'd479, 0);
		send_pixel(32'h1234_5678, 12'd0, 12'd479, 0);
		send_pixel(32'hA5A5_A5A5, 12'd4095, 12'd4095, 0);
		send_pixel(32'h5A5A_5A5A, 12'd4095, 12'd0, 0);
		send_pixel(32'hFF00_FF00, 12'd100, 12'd50, 0);
		// Portrait frame: the vertical offset is the one that gets scaled.
		set_frame(17'd1, 17'd4096, 17'd32768);
		send_pixel(32'hFFFF_FFFF, 12'd0, 12'd0, 0);
		send_pixel(32'h00FF_FFFF, 12'd0, 12'd4095, 0);
		send_pixel(32'h7777_7777, 12'd2000, 12'd2048, 0);
		// A zero-size vignette gives no falloff range, so pixels pass unchanged.
		set_frame(17'd640, 17'd480, 17'd0);
		send_pixel(32'hDEAD_BEEF, 12'd0, 12'd0, 0);
		// A size of one drops the inner limit to zero; only the exact center passes unchanged.
		set_frame(17'd4096, 17'd4096, 17'd65536);
		send_pixel(32'hFFFF_FFFF, 12'd2048, 12'd2048, 0);
		send_pixel(32'h0101_0101, 12'd0, 12'd0, 0);
		send_pixel(32'h4080_C0FF, 12'd4095, 12'd4095, 0);
		// Width values above the limit saturate; tiny frames stress the divider.
		set_frame(17'h1FFFF, 17'd2, 17'd131071);
		send_pixel(32'hFFFF_FFFF, 12'd4095, 12'd1, 0);
		send_pixel(32'h0102_0304, 12'd1, 12'd0, 0);
		set_frame(17'd1, 17'd1, 17'd65535);
		send_pixel(32'hFFFF_FFFF, 12'd0, 12'd0, 0);
		send_pixel(32'h8040_2010, 12'd4095, 12'd4095, 0);
	endtask

	// Random pixels across several frame settings, mostly inside the frame.
	task automatic test_random_frames();
		logic [11:0] c, r;
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: set_frame(17'd640, 17'd480, 17'd32768);
				1: set_frame(17'd4096, 17'd1, 17'd65536);
				2: set_frame(17'($urandom_range(1, 64)), 17'($urandom_range(1, 64)),
					17'($urandom_range(0, 131071)));
				default: set_frame(17'($urandom_range(1, 8191)),
					17'($urandom_range(1, 8191)), 17'($urandom_range(0, 131071)));
			endcase
			for (int i = 0; i < 100; i++) begin
				if ($urandom_range(0, 4) == 0) begin
					c = 12'($urandom);
					r = 12'($urandom);
				end else begin
					c = 12'($urandom_range(0, (frame_w > 0) ? frame_w - 1 : 0));
					r = 12'($urandom_range(0, (frame_h > 0) ? frame_h - 1 : 0));
				end
				send_pixel($urandom, c, r, phase != 3);
				// One pause lets the whole pipeline empty before more traffic.
				if (phase == 0 && i == 50) begin
					start <= 1'b0;
					while (pending_pixels.size() != 0)
						@(posedge clk);
				end
			end
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		pixel_in = '0;
		column = '0;
		row = '0;
		cfg_we = 1'b0;
		cfg_index = vdp_pkg::REG_WIDTH;
		cfg_data = '0;
		frame_w = 13'd640;
		frame_h = 13'd480;
		extent_q16 = 17'd32768;
		mismatch_count = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_frames();
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
